FILE: hw/rtl/orf3_pkg.sv
// Shared types, constants and helpers for the three-frame longest ORF finder
// Used by orf3_codon_decode, orf3_result and the top level
package orf3_pkg;

  // sequence length limit and derived counter width
  localparam int unsigned MaxNucleotides = 65536;
  localparam int unsigned PosW           = $clog2(MaxNucleotides + 2);

  // fixed field widths
  localparam int unsigned NtW    = 8;
  localparam int unsigned OffW   = 16;
  localparam int unsigned LenW   = 15;
  localparam int unsigned FrameW = 2;
  localparam int unsigned NumFrames = 3;

  localparam logic [LenW-1:0] LenMax      = '1;
  localparam logic [LenW-1:0] MinLenReset = LenW'(200);

  // output beat: accepted, start_offset, aa_length, overflow, zero fill
  localparam int unsigned OutFieldW = 1 + OffW + LenW + 1;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // nucleotide classes
  typedef enum logic [2:0] {
    CL_NONE = 3'd0,
    CL_A    = 3'd1,
    CL_C    = 3'd2,
    CL_G    = 3'd3,
    CL_T    = 3'd4,
    CL_U    = 3'd5,
    CL_R    = 3'd6
  } nt_class_e;

  // codon kinds
  typedef enum logic [1:0] {
    KIND_KNOWN   = 2'd0,
    KIND_UNKNOWN = 2'd1,
    KIND_STOP    = 2'd2
  } codon_kind_e;

  // one open run in a frame
  typedef struct packed {
    logic [OffW-1:0] start;
    logic [LenW-1:0] length;
    logic [LenW-1:0] lead_unknown;
    logic [LenW-1:0] known_end;
    logic            seen_known;
  } run_t;

  // best closed run so far
  typedef struct packed {
    logic [FrameW-1:0] frame;
    run_t              run;
  } best_t;

  // final result fields
  typedef struct packed {
    logic            accepted;
    logic [OffW-1:0] start_offset;
    logic [LenW-1:0] aa_length;
  } result_t;

  // empty run opened at a given offset
  function automatic run_t open_run(logic [OffW-1:0] start);
    run_t r;
    r              = '0;
    r.start        = start;
    return r;
  endfunction

  // keep the longer run, lower frame on equal length
  function automatic best_t close_run(best_t b, run_t r, logic [FrameW-1:0] f);
    best_t nb;
    nb = b;
    if ((r.length > b.run.length) || ((r.length == b.run.length) && (f < b.frame))) begin
      nb.frame = f;
      nb.run   = r;
    end
    return nb;
  endfunction

endpackage

FILE: hw/rtl/orf3_codon_decode.sv
// Nucleotide classifier and codon decoder for one codon per beat
// Depends on orf3_pkg
module orf3_codon_decode import orf3_pkg::*; (
  input  logic [NtW-1:0] nucleotide_i,
  input  logic [5:0]     prior_i,
  output nt_class_e      cls_o,
  output codon_kind_e    kind_o
);

  nt_class_e a_cls;
  nt_class_e b_cls;
  logic      has_t;
  logic      has_u;
  logic      has_r;

  // map the ascii character to a class
  always_comb begin
    case (nucleotide_i)
      8'h41:   cls_o = CL_A;
      8'h43:   cls_o = CL_C;
      8'h47:   cls_o = CL_G;
      8'h54:   cls_o = CL_T;
      8'h55:   cls_o = CL_U;
      8'h52:   cls_o = CL_R;
      default: cls_o = CL_NONE;
    endcase
  end

  assign a_cls = nt_class_e'(prior_i[5:3]);
  assign b_cls = nt_class_e'(prior_i[2:0]);

  assign has_t = (a_cls == CL_T) || (b_cls == CL_T) || (cls_o == CL_T);
  assign has_u = (a_cls == CL_U) || (b_cls == CL_U) || (cls_o == CL_U);
  assign has_r = (a_cls == CL_R) || (b_cls == CL_R) || (cls_o == CL_R);

  // stop, unknown or known amino acid
  always_comb begin
    kind_o = KIND_KNOWN;
    if ((a_cls == CL_NONE) || (b_cls == CL_NONE) || (cls_o == CL_NONE)) begin
      kind_o = KIND_UNKNOWN;
    end else if (((a_cls == CL_T) || (a_cls == CL_U)) && (b_cls == CL_A) &&
                 ((cls_o == CL_A) || (cls_o == CL_G) || (cls_o == CL_R))) begin
      kind_o = KIND_STOP;
    end else if (((a_cls == CL_T) || (a_cls == CL_U)) &&
                 ((b_cls == CL_G) || (b_cls == CL_R)) && (cls_o == CL_A)) begin
      kind_o = KIND_STOP;
    end else if (has_r || (has_t && has_u)) begin
      kind_o = KIND_UNKNOWN;
    end
  end

endmodule

FILE: hw/rtl/orf3_result.sv
// Final selection of the longest run and trimming of unknown codons
// Depends on orf3_pkg
module orf3_result import orf3_pkg::*; (
  input  run_t [NumFrames-1:0] runs_i,
  input  best_t                best_i,
  input  logic [LenW-1:0]      min_len_i,
  output result_t              result_o
);

  best_t           best;
  logic [OffW-1:0] lead_nt;

  // close the three open runs in frame order
  always_comb begin
    best = best_i;
    for (int i = 0; i < NumFrames; i++) begin
      best = close_run(best, runs_i[i], FrameW'(i));
    end
  end

  // leading unknown codons times three, in nucleotides
  assign lead_nt = OffW'({best.run.lead_unknown, 1'b0}) + OffW'(best.run.lead_unknown);

  // trim and gate by the minimum length
  always_comb begin
    result_o          = '0;
    result_o.accepted = (best.run.length >= min_len_i);
    if (result_o.accepted) begin
      if (best.run.seen_known) begin
        result_o.start_offset = best.run.start + lead_nt;
        result_o.aa_length    = best.run.known_end - best.run.lead_unknown;
      end else begin
        result_o.start_offset = best.run.start;
        result_o.aa_length    = best.run.length;
      end
    end
  end

endmodule

FILE: hw/rtl/three_frame_longest_orf_translator_unit.sv
// Three-frame longest open reading frame finder, top level
// Depends on orf3_pkg, orf3_codon_decode and orf3_result
//
//   channel  | dir | beat content
//   ---------+-----+-------------------------------------------------------------
//   s_axis   | in  | tdata[7:0] nucleotide, tlast last_in_sequence
//   m_axis   | out | tdata accepted, start_offset, aa_length, overflow, zero fill
//   cfg      | in  | cfg_wdata_i min_aa_length, written when cfg_we_i is high
//
// One nucleotide is taken every cycle while s_axis_tready is high; the per-frame
// run registers are updated in the cycle of the beat. A last beat loads a snapshot
// register, and the three runs are closed from it into the output register once
// that register is free. Input stalls only while a snapshot waits behind a held
// output beat. Reset clears all sequence state and sets min_aa_length to 200.
module three_frame_longest_orf_translator_unit import orf3_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [NtW-1:0]      s_axis_tdata,   // [7:0] nucleotide
  input  logic                s_axis_tlast,
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [0] accepted, [16:1] start_offset,
                                              // [31:17] aa_length, [32] overflow
  // configuration
  input  logic                cfg_we_i,
  input  logic [LenW-1:0]     cfg_wdata_i
);

  logic                 in_fire;
  logic                 out_load;

  logic [LenW-1:0]      min_len_q;

  logic [5:0]           prior_q, prior_d, prior_upd;
  logic [PosW-1:0]      pos_q, pos_d, pos_upd;
  logic [1:0]           phase_q, phase_d, phase_upd;
  run_t [NumFrames-1:0] runs_q, runs_d, runs_upd;
  best_t                best_q, best_d, best_upd;
  logic [FrameW-1:0]    cur_frame;

  nt_class_e            cls;
  codon_kind_e          kind;

  logic                 snap_valid_q, snap_valid_d;
  run_t [NumFrames-1:0] snap_runs_q;
  best_t                snap_best_q;
  logic                 snap_ovf_q;

  result_t              result;
  logic                 out_valid_q, out_valid_d;
  result_t              out_result_q;
  logic                 out_ovf_q;

  // handshakes
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = snap_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !snap_valid_q || out_load;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MinLenReset;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_wdata_i;
    end
  end

  orf3_codon_decode u_decode (
    .nucleotide_i (s_axis_tdata),
    .prior_i      (prior_q),
    .cls_o        (cls),
    .kind_o       (kind)
  );

  // frame of the codon ending at this nucleotide
  always_comb begin
    case (phase_q)
      2'd0:    cur_frame = FrameW'(1);
      2'd1:    cur_frame = FrameW'(2);
      default: cur_frame = FrameW'(0);
    endcase
  end

  // sequence state update for one beat
  always_comb begin
    prior_upd = prior_q;
    pos_upd   = pos_q;
    phase_upd = phase_q;
    runs_upd  = runs_q;
    best_upd  = best_q;
    if (pos_q < PosW'(MaxNucleotides)) begin
      if (pos_q >= PosW'(2)) begin
        for (int i = 0; i < NumFrames; i++) begin
          if (cur_frame == FrameW'(i)) begin
            if (kind == KIND_STOP) begin
              best_upd    = close_run(best_q, runs_q[i], FrameW'(i));
              runs_upd[i] = open_run(OffW'(pos_q + PosW'(1)));
            end else begin
              if (runs_q[i].length < LenMax) begin
                runs_upd[i].length = runs_q[i].length + LenW'(1);
              end
              if (kind == KIND_UNKNOWN) begin
                if (!runs_q[i].seen_known && (runs_q[i].lead_unknown < LenMax)) begin
                  runs_upd[i].lead_unknown = runs_q[i].lead_unknown + LenW'(1);
                end
              end else begin
                runs_upd[i].seen_known = 1'b1;
                runs_upd[i].known_end  = runs_upd[i].length;
              end
            end
          end
        end
      end
      prior_upd = {prior_q[2:0], cls};
      phase_upd = (phase_q >= 2'd2) ? 2'd0 : phase_q + 2'd1;
      pos_upd   = pos_q + PosW'(1);
    end else begin
      pos_upd = PosW'(MaxNucleotides + 1);
    end
  end

  // clear after the last beat of a sequence
  always_comb begin
    prior_d = prior_upd;
    pos_d   = pos_upd;
    phase_d = phase_upd;
    runs_d  = runs_upd;
    best_d  = best_upd;
    if (s_axis_tlast) begin
      prior_d = '0;
      pos_d   = '0;
      phase_d = '0;
      for (int i = 0; i < NumFrames; i++) begin
        runs_d[i] = open_run(OffW'(i));
      end
      best_d = '0;
    end
  end

  // sequence state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q <= '0;
      pos_q   <= '0;
      phase_q <= '0;
      for (int i = 0; i < NumFrames; i++) begin
        runs_q[i] <= open_run(OffW'(i));
      end
      best_q  <= '0;
    end else if (in_fire) begin
      prior_q <= prior_d;
      pos_q   <= pos_d;
      phase_q <= phase_d;
      runs_q  <= runs_d;
      best_q  <= best_d;
    end
  end

  // snapshot stage control
  always_comb begin
    snap_valid_d = snap_valid_q;
    if (out_load) begin
      snap_valid_d = 1'b0;
    end
    if (in_fire && s_axis_tlast) begin
      snap_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else begin
      snap_valid_q <= snap_valid_d;
    end
  end

  // snapshot payload
  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tlast) begin
      snap_runs_q <= runs_upd;
      snap_best_q <= best_upd;
      snap_ovf_q  <= (pos_upd > PosW'(MaxNucleotides));
    end
  end

  orf3_result u_result (
    .runs_i    (snap_runs_q),
    .best_i    (snap_best_q),
    .min_len_i (min_len_q),
    .result_o  (result)
  );

  // output register control
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_result_q <= result;
      out_ovf_q    <= snap_ovf_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'({out_ovf_q, out_result_q.aa_length,
                                    out_result_q.start_offset, out_result_q.accepted});

endmodule
